### hdl/ialru_pkg.sv
`default_nettype none

package ialru_pkg;

    // Geometry of the cache. SETS must be a power of two of at least 2.
    localparam int WAYS = 16;
    localparam int CPUS = 4;
    localparam int SETS = 2048;

    // Fixed field widths of the request and result items.
    localparam int SET_W  = 11;
    localparam int CPU_W  = 2;
    localparam int WAY_W  = 4;
    localparam int RANK_W = 4;
    localparam int PRES_W = 64;

    // Derived sizes.
    localparam int SET_AW = $clog2(SETS);
    localparam int ROW_W  = WAYS * RANK_W;
    localparam int TREE_N = 2 ** WAY_W;

    // Request payload layout, lowest bit first.
    localparam int SET_OFF   = 0;
    localparam int CPU_OFF   = SET_OFF + SET_W;
    localparam int AWAY_OFF  = CPU_OFF + CPU_W;
    localparam int HIT_OFF   = AWAY_OFF + WAY_W;
    localparam int WB_OFF    = HIT_OFF + 1;
    localparam int VALID_OFF = WB_OFF + 1;
    localparam int PRES_OFF  = VALID_OFF + 16;
    localparam int IN_BITS   = PRES_OFF + PRES_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

    // Result payload layout.
    localparam int OUT_W = 8;

    // Request kinds carried on the input user sideband.
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Victim classes.
    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_NO_L2   = 2'd1;
    localparam logic [1:0] CLS_OWN_L2  = 2'd2;
    localparam logic [1:0] CLS_LRU     = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } state_t;

    // Rank row after reset: each way's rank equals its index.
    function automatic logic [ROW_W-1:0] reset_row();
        logic [ROW_W-1:0] row;
        row = '0;
        for (int w = 0; w < WAYS; w++) begin
            row[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
        return row;
    endfunction

endpackage

`default_nettype wire

### hdl/inclusion_aware_lru_victim_select_top.sv
`default_nettype none

// Inclusion-aware LRU victim selection for a shared last-level cache.
// Input channel s_*: one request per transfer; s_tuser selects find-victim
// or rank update, s_tdata carries set, core, way, hit/writeback flags, the
// valid mask and the per-way, per-core L2 presence bits.
// Output channel m_*: exactly one result per request, in request order;
// m_tuser marks a find-victim answer, m_tdata carries way and class.
// Each request has its set's rank row read from the rank memory into a
// register as the request is taken; in the compute state the block then
// selects the victim or promotes the accessed way and writes the row back.
// The result is registered when the compute state retires; a new request
// is taken only once the previous one has left the compute state.
// The result sits in an output register, so the next request is taken
// while a result still waits. If the receiver stalls, the block takes
// the next request and holds in its compute state until the output frees.
// After reset the block sweeps the rank memory one row per cycle over all
// SETS rows (2048), restoring rank = way index; s_tready stays low meanwhile.
module inclusion_aware_lru_victim_select_top (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // s_tdata: set_index[10:0], requester_cpu[12:11], access_way[16:13],
    // was_hit[17], is_writeback[18], valid_mask[34:19], l2_presence[98:35]
    input  wire logic [ialru_pkg::IN_W-1:0] s_tdata,
    // s_tuser: operation[0]
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // m_tdata: victim_way[3:0], victim_class[5:4]
    output logic [ialru_pkg::OUT_W-1:0]  m_tdata,
    // m_tuser: is_victim_result[0]
    output logic                         m_tuser
);

    localparam int SET_AW = ialru_pkg::SET_AW;
    localparam int ROW_W  = ialru_pkg::ROW_W;
    localparam int RANK_W = ialru_pkg::RANK_W;
    localparam int WAY_W  = ialru_pkg::WAY_W;
    localparam int TREE_N = ialru_pkg::TREE_N;
    localparam int WAYS   = ialru_pkg::WAYS;
    localparam int CPUS   = ialru_pkg::CPUS;

    // Rank memory: one row of WAYS ranks per set.
    logic [ROW_W-1:0] rank_mem [ialru_pkg::SETS];
    logic [ROW_W-1:0] rd_row_reg;

    ialru_pkg::state_t state_reg, state_next;
    logic [SET_AW-1:0] clr_addr_reg, clr_addr_next;

    // Request held for the compute cycle.
    logic [SET_AW-1:0]           req_set_reg;
    logic                        req_op_reg;
    logic [ialru_pkg::CPU_W-1:0] req_cpu_reg;
    logic [WAY_W-1:0]            req_way_reg;
    logic                        req_hit_reg;
    logic                        req_wb_reg;
    logic [15:0]                 req_valid_reg;
    logic [ialru_pkg::PRES_W-1:0] req_pres_reg;

    // Output register.
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [ialru_pkg::OUT_W-1:0] m_tdata_reg;
    logic                       m_tuser_reg;

    logic s_xfer;
    logic out_load;
    logic mem_we;
    logic [SET_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;

    // Compute cycle signals.
    logic [RANK_W-1:0] ranks [TREE_N];
    logic [TREE_N-1:0] free_mask, own_mask, sel_mask;
    logic              inv_found;
    logic [WAY_W-1:0]  inv_way;
    logic [1:0]        sel_class;
    logic [RANK_W-1:0] node_rank [2*TREE_N];
    logic [WAY_W-1:0]  node_way  [2*TREE_N];
    logic              node_ok   [2*TREE_N];
    logic [RANK_W-1:0] acc_rank;
    logic              promote_en;
    logic [ROW_W-1:0]  promoted_row;
    logic [WAY_W-1:0]  res_way;
    logic [1:0]        res_class;

    assign s_tready = (state_reg == ialru_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Unpack the row and classify each way by its L2 holders.
    always_comb begin
        logic own_bit;
        logic others;
        for (int w = 0; w < TREE_N; w++) begin
            own_bit = 1'b0;
            others  = 1'b0;
            if (w < WAYS) begin
                ranks[w] = rd_row_reg[w*RANK_W +: RANK_W];
                for (int c = 0; c < CPUS; c++) begin
                    if (req_pres_reg[w*4 + c]) begin
                        if (req_cpu_reg == ialru_pkg::CPU_W'(c)) begin
                            own_bit = 1'b1;
                        end else begin
                            others = 1'b1;
                        end
                    end
                end
                free_mask[w] = !own_bit && !others;
                own_mask[w]  = own_bit && !others;
            end else begin
                ranks[w]     = '0;
                free_mask[w] = 1'b0;
                own_mask[w]  = 1'b0;
            end
        end
    end

    // First invalid way, lowest index first.
    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!req_valid_reg[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
    end

    // Candidate set by priority of class.
    always_comb begin
        priority if (|free_mask) begin
            sel_mask  = free_mask;
            sel_class = ialru_pkg::CLS_NO_L2;
        end else if (|own_mask) begin
            sel_mask  = own_mask;
            sel_class = ialru_pkg::CLS_OWN_L2;
        end else begin
            for (int w = 0; w < TREE_N; w++) begin
                sel_mask[w] = (w < WAYS);
            end
            sel_class = ialru_pkg::CLS_LRU;
        end
    end

    // Oldest candidate through a compare tree; the lower way wins ties.
    always_comb begin
        node_rank[0] = '0;
        node_way[0]  = '0;
        node_ok[0]   = 1'b0;
        for (int i = 0; i < TREE_N; i++) begin
            node_rank[TREE_N + i] = ranks[i];
            node_way[TREE_N + i]  = WAY_W'(i);
            node_ok[TREE_N + i]   = sel_mask[i];
        end
        for (int n = TREE_N - 1; n >= 1; n--) begin
            if (node_ok[2*n + 1] &&
                (!node_ok[2*n] || node_rank[2*n + 1] > node_rank[2*n])) begin
                node_rank[n] = node_rank[2*n + 1];
                node_way[n]  = node_way[2*n + 1];
            end else begin
                node_rank[n] = node_rank[2*n];
                node_way[n]  = node_way[2*n];
            end
            node_ok[n] = node_ok[2*n] || node_ok[2*n + 1];
        end
    end

    // Promotion of the accessed way to rank 0, aging the younger ways.
    always_comb begin
        acc_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (req_way_reg == WAY_W'(w)) begin
                acc_rank = ranks[w];
            end
        end
        promote_en = (32'(req_way_reg) < WAYS) && !(req_hit_reg && req_wb_reg);
        for (int w = 0; w < WAYS; w++) begin
            if (req_way_reg == WAY_W'(w)) begin
                promoted_row[w*RANK_W +: RANK_W] = '0;
            end else if (ranks[w] < acc_rank) begin
                promoted_row[w*RANK_W +: RANK_W] = ranks[w] + RANK_W'(1);
            end else begin
                promoted_row[w*RANK_W +: RANK_W] = ranks[w];
            end
        end
    end

    // Result fields.
    always_comb begin
        if (req_op_reg == ialru_pkg::OP_UPDATE) begin
            res_way   = '0;
            res_class = ialru_pkg::CLS_INVALID;
        end else if (inv_found) begin
            res_way   = inv_way;
            res_class = ialru_pkg::CLS_INVALID;
        end else begin
            res_way   = node_way[1];
            res_class = sel_class;
        end
    end

    // Sequencer: clearing sweep, wait for a request, compute and retire.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = req_set_reg;
        mem_wdata     = promoted_row;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ialru_pkg::ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = ialru_pkg::reset_row();
                clr_addr_next = clr_addr_reg + SET_AW'(1);
                if (clr_addr_reg == SET_AW'(ialru_pkg::SETS - 1)) begin
                    state_next = ialru_pkg::ST_IDLE;
                end
            end
            ialru_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ialru_pkg::ST_CALC;
                end
            end
            ialru_pkg::ST_CALC: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    mem_we        = (req_op_reg == ialru_pkg::OP_UPDATE) && promote_en;
                    state_next    = ialru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ialru_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ialru_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Request capture on transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_set_reg   <= s_tdata[ialru_pkg::SET_OFF +: SET_AW];
            req_op_reg    <= s_tuser;
            req_cpu_reg   <= s_tdata[ialru_pkg::CPU_OFF +: ialru_pkg::CPU_W];
            req_way_reg   <= s_tdata[ialru_pkg::AWAY_OFF +: WAY_W];
            req_hit_reg   <= s_tdata[ialru_pkg::HIT_OFF];
            req_wb_reg    <= s_tdata[ialru_pkg::WB_OFF];
            req_valid_reg <= s_tdata[ialru_pkg::VALID_OFF +: 16];
            req_pres_reg  <= s_tdata[ialru_pkg::PRES_OFF +: ialru_pkg::PRES_W];
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, res_class, res_way};
            m_tuser_reg <= (req_op_reg == ialru_pkg::OP_FIND);
        end
    end

    // Rank memory write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rank_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Rank memory read port, registered data.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rd_row_reg <= rank_mem[s_tdata[ialru_pkg::SET_OFF +: SET_AW]];
        end
    end

endmodule

`default_nettype wire

### hdl/ialru_checker.sv
`default_nettype none

module ialru_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [ialru_pkg::IN_W-1:0]  s_tdata,
    input wire logic                        s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [ialru_pkg::OUT_W-1:0] m_tdata,
    input wire logic                        m_tuser
);

    // A stalled result keeps its valid and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Requests are taken one at a time: no transfer in the cycle after one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

    // An update result carries way zero and class zero; padding stays zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("update result carries nonzero payload");

    // Reset drops the result and starts the clearing sweep.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("block not quiet after reset");

endmodule

bind inclusion_aware_lru_victim_select_top ialru_checker u_ialru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
